// ===== hdl/tcr_pkg.sv =====
// shared constants and types for the triangle / circle relation block
package tcr_pkg;

    localparam int TCR_COORD_BITS = 16;
    localparam int RAD_BITS       = 16;
    localparam int R2_BITS        = 2 * RAD_BITS;
    localparam int REL_BITS       = 2;

    typedef logic [REL_BITS-1:0] t_rel;

    localparam t_rel REL_CIRCLE_IN   = 2'd0;
    localparam t_rel REL_TRIANGLE_IN = 2'd1;
    localparam t_rel REL_INTERSECT   = 2'd2;
    localparam t_rel REL_DISJOINT    = 2'd3;

endpackage

// ===== hdl/tcr_if.sv =====
// request channel interfaces for triangle and circle items and relation results
interface tcr_in_if import tcr_pkg::*; #(
    parameter int COORD_BITS = TCR_COORD_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_a_x;
    logic signed [COORD_BITS-1:0] vertex_a_y;
    logic signed [COORD_BITS-1:0] vertex_b_x;
    logic signed [COORD_BITS-1:0] vertex_b_y;
    logic signed [COORD_BITS-1:0] vertex_c_x;
    logic signed [COORD_BITS-1:0] vertex_c_y;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic        [RAD_BITS-1:0]   radius;

    modport source (
        output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y, center_x, center_y, radius,
        input  ready
    );
    modport sink (
        input  valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y, center_x, center_y, radius,
        output ready
    );
endinterface

interface tcr_out_if import tcr_pkg::*; ();
    logic valid;
    logic ready;
    t_rel relation;

    modport source (output valid, relation, input ready);
    modport sink (input valid, relation, output ready);
endinterface

// ===== hdl/tcr_wmul.sv =====
// two-stage unsigned multiplier built from four registered partial products
module tcr_wmul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic             i_clk,
    input  logic             i_en_a,
    input  logic             i_en_b,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_p
);
    localparam int LA = AW / 2;
    localparam int HA = AW - LA;
    localparam int LB = BW / 2;
    localparam int HB = BW - LB;
    localparam int PW = AW + BW;

    logic [LA+LB-1:0] r_ll;
    logic [LA+HB-1:0] r_lh;
    logic [HA+LB-1:0] r_hl;
    logic [HA+HB-1:0] r_hh;
    logic [PW-1:0]    r_p;

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_ll <= i_a[LA-1:0]  * i_b[LB-1:0];
            r_lh <= i_a[LA-1:0]  * i_b[BW-1:LB];
            r_hl <= i_a[AW-1:LA] * i_b[LB-1:0];
            r_hh <= i_a[AW-1:LA] * i_b[BW-1:LB];
        end
        if (i_en_b) begin
            r_p <= (PW'(r_hh) << (LA + LB)) + (PW'(r_hl) << LB)
                 + (PW'(r_lh) << LA) + PW'(r_ll);
        end
    end

    assign o_p = r_p;
endmodule

// ===== hdl/triangle_circle_relation_core.sv =====
// top level of the triangle / circle relation classifier pipeline
// Takes one request per cycle while the output is not held (triangle a, b, c,
// centre p, radius r) and returns one relation code per request: circle inside
// triangle, triangle inside circle, intersect or disjoint, all from exact integer
// squared-distance compares. The pipeline is seven register stages deep, and a new
// request can enter every cycle while the output is not held. Each stage has its
// own valid bit and moves up whenever it is empty or the stage after it moves, so a
// held output only stops the stages that are full behind it. Stage depth is set by
// one coordinate-product multiplier row and by the wide cross-magnitude and
// radius-length products, which are split into partial products over two stages.
module triangle_circle_relation_core import tcr_pkg::*; #(
    parameter int COORD_BITS = TCR_COORD_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    tcr_in_if.sink  i_in,
    tcr_out_if.source o_out
);
    localparam int DW   = COORD_BITS + 1;      // coordinate difference
    localparam int PW   = 2 * DW;              // product of two differences
    localparam int SW   = PW + 1;              // sum of two products
    localparam int UW   = 2 * COORD_BITS + 1;  // squared length, cross magnitude
    localparam int NSTG = 7;
    localparam int NPR  = 13;                  // product pairs
    localparam int NCR  = 4;                   // leading pairs are cross products

    // pair order: d1 (ab), d2 (bc), d3 (ca), tri, dot ab, dot ac, dot bc,
    // |pa|, |pb|, |pc|, |ab|, |ac|, |bc|
    localparam int S_D1  = 0;
    localparam int S_D2  = 1;
    localparam int S_D3  = 2;
    localparam int S_TRI = 3;
    localparam int S_DAB = 4;
    localparam int S_DAC = 5;
    localparam int S_DBC = 6;
    localparam int S_PA  = 7;
    localparam int S_PB  = 8;
    localparam int S_PC  = 9;
    localparam int S_AB  = 10;
    localparam int S_AC  = 11;
    localparam int S_BC  = 12;

    // edge order for the wide compares: ab, ac, bc
    localparam int E_AB = 0;
    localparam int E_AC = 1;
    localparam int E_BC = 2;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;
    logic            in_fire;

    // stage handshake: a stage moves when empty or when the one after it moves
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || o_out.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_in.ready = en[0];
    assign in_fire    = i_in.valid && en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= in_fire;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0: edge vectors, centre offsets, bounding box for flat triangles
    logic signed [DW-1:0] r0_ab_x, r0_ab_y, r0_ac_x, r0_ac_y, r0_bc_x, r0_bc_y;
    logic signed [DW-1:0] r0_pa_x, r0_pa_y, r0_pb_x, r0_pb_y, r0_pc_x, r0_pc_y;
    logic [RAD_BITS-1:0]  r0_rad;
    logic                 r0_bbox;
    logic                 n0_bbox;

    always_comb begin
        n0_bbox = (i_in.center_x >= i_in.vertex_a_x || i_in.center_x >= i_in.vertex_b_x
                   || i_in.center_x >= i_in.vertex_c_x)
               && (i_in.center_x <= i_in.vertex_a_x || i_in.center_x <= i_in.vertex_b_x
                   || i_in.center_x <= i_in.vertex_c_x)
               && (i_in.center_y >= i_in.vertex_a_y || i_in.center_y >= i_in.vertex_b_y
                   || i_in.center_y >= i_in.vertex_c_y)
               && (i_in.center_y <= i_in.vertex_a_y || i_in.center_y <= i_in.vertex_b_y
                   || i_in.center_y <= i_in.vertex_c_y);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_ab_x <= DW'(i_in.vertex_b_x) - DW'(i_in.vertex_a_x);
            r0_ab_y <= DW'(i_in.vertex_b_y) - DW'(i_in.vertex_a_y);
            r0_ac_x <= DW'(i_in.vertex_c_x) - DW'(i_in.vertex_a_x);
            r0_ac_y <= DW'(i_in.vertex_c_y) - DW'(i_in.vertex_a_y);
            r0_bc_x <= DW'(i_in.vertex_c_x) - DW'(i_in.vertex_b_x);
            r0_bc_y <= DW'(i_in.vertex_c_y) - DW'(i_in.vertex_b_y);
            r0_pa_x <= DW'(i_in.center_x) - DW'(i_in.vertex_a_x);
            r0_pa_y <= DW'(i_in.center_y) - DW'(i_in.vertex_a_y);
            r0_pb_x <= DW'(i_in.center_x) - DW'(i_in.vertex_b_x);
            r0_pb_y <= DW'(i_in.center_y) - DW'(i_in.vertex_b_y);
            r0_pc_x <= DW'(i_in.center_x) - DW'(i_in.vertex_c_x);
            r0_pc_y <= DW'(i_in.center_y) - DW'(i_in.vertex_c_y);
            r0_rad  <= i_in.radius;
            r0_bbox <= n0_bbox;
        end
    end

    // stage 1: one row of coordinate products
    logic signed [DW-1:0] op_a [2*NPR];
    logic signed [DW-1:0] op_b [2*NPR];
    logic signed [PW-1:0] r1_p [2*NPR];
    logic [R2_BITS-1:0]   r1_r2;
    logic                 r1_bbox;

    always_comb begin
        op_a[0]  = r0_ab_x; op_b[0]  = r0_pa_y;
        op_a[1]  = r0_ab_y; op_b[1]  = r0_pa_x;
        op_a[2]  = r0_bc_x; op_b[2]  = r0_pb_y;
        op_a[3]  = r0_bc_y; op_b[3]  = r0_pb_x;
        op_a[4]  = r0_ac_y; op_b[4]  = r0_pc_x;
        op_a[5]  = r0_ac_x; op_b[5]  = r0_pc_y;
        op_a[6]  = r0_ab_x; op_b[6]  = r0_ac_y;
        op_a[7]  = r0_ab_y; op_b[7]  = r0_ac_x;
        op_a[8]  = r0_pa_x; op_b[8]  = r0_ab_x;
        op_a[9]  = r0_pa_y; op_b[9]  = r0_ab_y;
        op_a[10] = r0_pa_x; op_b[10] = r0_ac_x;
        op_a[11] = r0_pa_y; op_b[11] = r0_ac_y;
        op_a[12] = r0_pb_x; op_b[12] = r0_bc_x;
        op_a[13] = r0_pb_y; op_b[13] = r0_bc_y;
        op_a[14] = r0_pa_x; op_b[14] = r0_pa_x;
        op_a[15] = r0_pa_y; op_b[15] = r0_pa_y;
        op_a[16] = r0_pb_x; op_b[16] = r0_pb_x;
        op_a[17] = r0_pb_y; op_b[17] = r0_pb_y;
        op_a[18] = r0_pc_x; op_b[18] = r0_pc_x;
        op_a[19] = r0_pc_y; op_b[19] = r0_pc_y;
        op_a[20] = r0_ab_x; op_b[20] = r0_ab_x;
        op_a[21] = r0_ab_y; op_b[21] = r0_ab_y;
        op_a[22] = r0_ac_x; op_b[22] = r0_ac_x;
        op_a[23] = r0_ac_y; op_b[23] = r0_ac_y;
        op_a[24] = r0_bc_x; op_b[24] = r0_bc_x;
        op_a[25] = r0_bc_y; op_b[25] = r0_bc_y;
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int k = 0; k < 2 * NPR; k++) begin
                r1_p[k] <= PW'(op_a[k]) * PW'(op_b[k]);
            end
            r1_r2   <= R2_BITS'(r0_rad) * R2_BITS'(r0_rad);
            r1_bbox <= r0_bbox;
        end
    end

    // stage 2: cross products, dot products and squared lengths
    logic signed [SW-1:0] r2_s [NPR];
    logic [R2_BITS-1:0]   r2_r2;
    logic                 r2_bbox;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int k = 0; k < NPR; k++) begin
                if (k < NCR) begin
                    r2_s[k] <= SW'(r1_p[2*k]) - SW'(r1_p[2*k+1]);
                end else begin
                    r2_s[k] <= SW'(r1_p[2*k]) + SW'(r1_p[2*k+1]);
                end
            end
            r2_r2   <= r1_r2;
            r2_bbox <= r1_bbox;
        end
    end

    // stage 3: containment, vertex compares, foot-on-segment checks, magnitudes
    logic                 n3_inside;
    logic [UW-1:0]        n3_c   [3];
    logic [UW-1:0]        n3_len [3];
    logic signed [SW-1:0] n3_dot [3];
    logic signed [SW-1:0] n3_neg;
    logic [2:0]           n3_zl_clear;
    logic [2:0]           n3_on_seg;
    logic [UW-1:0]        da, db, dc;
    logic                 neg, pos;

    logic                 r3_inside;
    logic [UW-1:0]        r3_c   [3];
    logic [UW-1:0]        r3_len [3];
    logic [R2_BITS-1:0]   r3_r2;
    logic [2:0]           r3_zl_clear;
    logic [2:0]           r3_on_seg;
    logic                 r3_vtx_clear;
    logic                 r3_reach_all;

    always_comb begin
        da = r2_s[S_PA][UW-1:0];
        db = r2_s[S_PB][UW-1:0];
        dc = r2_s[S_PC][UW-1:0];
        n3_len[E_AB] = r2_s[S_AB][UW-1:0];
        n3_len[E_AC] = r2_s[S_AC][UW-1:0];
        n3_len[E_BC] = r2_s[S_BC][UW-1:0];
        n3_dot[E_AB] = r2_s[S_DAB];
        n3_dot[E_AC] = r2_s[S_DAC];
        n3_dot[E_BC] = r2_s[S_DBC];
        // edge ac uses the ca cross product, same magnitude
        n3_neg = -r2_s[S_D1];
        n3_c[E_AB] = r2_s[S_D1][SW-1] ? n3_neg[UW-1:0] : r2_s[S_D1][UW-1:0];
        n3_neg = -r2_s[S_D3];
        n3_c[E_AC] = r2_s[S_D3][SW-1] ? n3_neg[UW-1:0] : r2_s[S_D3][UW-1:0];
        n3_neg = -r2_s[S_D2];
        n3_c[E_BC] = r2_s[S_D2][SW-1] ? n3_neg[UW-1:0] : r2_s[S_D2][UW-1:0];

        neg = r2_s[S_D1] < 0 || r2_s[S_D2] < 0 || r2_s[S_D3] < 0;
        pos = r2_s[S_D1] > 0 || r2_s[S_D2] > 0 || r2_s[S_D3] > 0;
        if (r2_s[S_TRI] != '0) begin
            n3_inside = !(neg && pos);
        end else begin
            // flat triangle: centre must sit on the line within the bounding box
            n3_inside = !neg && !pos && r2_bbox;
        end

        // a zero-length edge falls back to the distance to its first vertex
        n3_zl_clear[E_AB] = r2_r2 <= da;
        n3_zl_clear[E_AC] = r2_r2 <= da;
        n3_zl_clear[E_BC] = r2_r2 <= db;

        for (int e = 0; e < 3; e++) begin
            n3_on_seg[e] = n3_len[e] != '0 && !n3_dot[e][SW-1]
                        && n3_dot[e][SW-2:0] <= {1'b0, n3_len[e]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_inside    <= n3_inside;
            r3_c         <= n3_c;
            r3_len       <= n3_len;
            r3_r2        <= r2_r2;
            r3_zl_clear  <= n3_zl_clear;
            r3_on_seg    <= n3_on_seg;
            r3_vtx_clear <= da > r2_r2 && db > r2_r2 && dc > r2_r2;
            r3_reach_all <= r2_r2 >= da && r2_r2 >= db && r2_r2 >= dc;
        end
    end

    // stages 4 and 5: squared cross magnitude and radius times squared length
    logic [2*UW-1:0]      cc [3];
    logic [R2_BITS+UW-1:0] rl [3];

    for (genvar e = 0; e < 3; e++) begin : g_wide
        tcr_wmul #(.AW(UW), .BW(UW)) u_cc (
            .i_clk  (i_clk),
            .i_en_a (en[4]),
            .i_en_b (en[5]),
            .i_a    (r3_c[e]),
            .i_b    (r3_c[e]),
            .o_p    (cc[e])
        );
        tcr_wmul #(.AW(R2_BITS), .BW(UW)) u_rl (
            .i_clk  (i_clk),
            .i_en_a (en[4]),
            .i_en_b (en[5]),
            .i_a    (r3_r2),
            .i_b    (r3_len[e]),
            .o_p    (rl[e])
        );
    end

    logic       r4_inside, r5_inside;
    logic [2:0] r4_zl_clear, r5_zl_clear, r4_on_seg, r5_on_seg;
    logic [2:0] r4_zero, r5_zero;
    logic       r4_vtx_clear, r5_vtx_clear, r4_reach_all, r5_reach_all;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_inside    <= r3_inside;
            r4_zl_clear  <= r3_zl_clear;
            r4_on_seg    <= r3_on_seg;
            r4_vtx_clear <= r3_vtx_clear;
            r4_reach_all <= r3_reach_all;
            for (int e = 0; e < 3; e++) begin
                r4_zero[e] <= r3_len[e] == '0;
            end
        end
        if (en[5]) begin
            r5_inside    <= r4_inside;
            r5_zl_clear  <= r4_zl_clear;
            r5_on_seg    <= r4_on_seg;
            r5_zero      <= r4_zero;
            r5_vtx_clear <= r4_vtx_clear;
            r5_reach_all <= r4_reach_all;
        end
    end

    // stage 6: line and segment compares, final classification, output register
    logic [2:0] line_clear, seg_reach;
    t_rel       n6_rel;
    t_rel       r6_rel;

    always_comb begin
        for (int e = 0; e < 3; e++) begin
            line_clear[e] = r5_zero[e] ? r5_zl_clear[e] : rl[e] <= cc[e];
            seg_reach[e]  = r5_on_seg[e] && cc[e] <= rl[e];
        end
        if (r5_inside && (&line_clear)) begin
            n6_rel = REL_CIRCLE_IN;
        end else if (!r5_inside && r5_vtx_clear && !(|seg_reach)) begin
            n6_rel = REL_DISJOINT;
        end else if (r5_reach_all) begin
            n6_rel = REL_TRIANGLE_IN;
        end else begin
            n6_rel = REL_INTERSECT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_rel <= n6_rel;
        end
    end

    assign o_out.valid    = r_vld[NSTG-1];
    assign o_out.relation = r6_rel;

    // reset empties every stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> r_vld == '0)
        else $error("pipeline not empty after reset");

    // the full stage before the output stage keeps its request while it cannot move
    a_hold_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-2] && !en[NSTG-2]) |=> r_vld[NSTG-2])
        else $error("request lost from a held stage");

    // back-pressure at the input only when the whole pipeline is full and held
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_vld == '1 && !o_out.ready))
        else $error("input held while the pipeline has room");

    // a centre found inside never reports disjoint
    a_inside_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en[6] && r_vld[NSTG-2] && r5_inside) |=> r6_rel != REL_DISJOINT)
        else $error("inside centre classified disjoint");
endmodule

// ===== dv/triangle_circle_relation_core_checker.sv =====
// relation checker: watches both channels, predicts each relation and compares
`timescale 1ns / 100ps

module triangle_circle_relation_core_checker import tcr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    tcr_in_if    i_in,
    tcr_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);

    t_rel relation_fifo[$];
    int   mismatch_count = 0;
    int   result_index   = 0;

    function automatic longint cross3(longint ox, longint oy, longint ux, longint uy,
                                      longint vx, longint vy);
        return (ux - ox) * (vy - oy) - (uy - oy) * (vx - ox);
    endfunction

    function automatic longint dsq(longint ax, longint ay, longint bx, longint by);
        return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // edge line (u,v) at least r from p; a point edge measures to u
    function automatic bit line_clear(longint px, longint py, longint ux, longint uy,
                                      longint vx, longint vy, longint r2);
        longint   len2;
        longint   c;
        len2 = dsq(ux, uy, vx, vy);
        if (len2 == 0) return r2 <= dsq(px, py, ux, uy);
        c = mag(cross3(ux, uy, vx, vy, px, py));
        return (128'(r2) * 128'(len2)) <= (128'(c) * 128'(c));
    endfunction

    // perpendicular foot on closed segment and within r
    function automatic bit seg_reach(longint px, longint py, longint ux, longint uy,
                                     longint vx, longint vy, longint r2);
        longint len2;
        longint d;
        longint c;
        len2 = dsq(ux, uy, vx, vy);
        if (len2 == 0) return 0;
        d = (px - ux) * (vx - ux) + (py - uy) * (vy - uy);
        if (d < 0 || d > len2) return 0;
        c = mag(cross3(ux, uy, vx, vy, px, py));
        return (128'(c) * 128'(c)) <= (128'(r2) * 128'(len2));
    endfunction

    function automatic t_rel classify(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy, longint px, longint py,
                                      longint r);
        longint r2, d1, d2, d3, da, db, dc, far;
        bit     in_tri, neg, pos;
        r2 = r * r;
        d1 = cross3(ax, ay, bx, by, px, py);
        d2 = cross3(bx, by, cx, cy, px, py);
        d3 = cross3(cx, cy, ax, ay, px, py);
        da = dsq(ax, ay, px, py);
        db = dsq(bx, by, px, py);
        dc = dsq(cx, cy, px, py);
        far = da > db ? da : db;
        if (far < dc) far = dc;
        if (cross3(ax, ay, bx, by, cx, cy) != 0) begin
            neg = d1 < 0 || d2 < 0 || d3 < 0;
            pos = d1 > 0 || d2 > 0 || d3 > 0;
            in_tri = !(neg && pos);
        end else begin
            // collinear vertices: on the line and inside the bounding box
            in_tri = d1 == 0 && d2 == 0 && d3 == 0
                && (px >= ax || px >= bx || px >= cx)
                && (px <= ax || px <= bx || px <= cx)
                && (py >= ay || py >= by || py >= cy)
                && (py <= ay || py <= by || py <= cy);
        end
        if (in_tri && line_clear(px, py, ax, ay, bx, by, r2)
                && line_clear(px, py, ax, ay, cx, cy, r2)
                && line_clear(px, py, bx, by, cx, cy, r2))
            return REL_CIRCLE_IN;
        if (!in_tri && da > r2 && db > r2 && dc > r2
                && !seg_reach(px, py, ax, ay, bx, by, r2)
                && !seg_reach(px, py, ax, ay, cx, cy, r2)
                && !seg_reach(px, py, bx, by, cx, cy, r2))
            return REL_DISJOINT;
        if (r2 >= far) return REL_TRIANGLE_IN;
        return REL_INTERSECT;
    endfunction

    always_ff @(posedge i_clk) begin
        t_rel want;
        t_rel pred;
        if (i_rst_n && i_in.valid && i_in.ready) begin
            pred = classify(i_in.vertex_a_x, i_in.vertex_a_y,
                i_in.vertex_b_x, i_in.vertex_b_y, i_in.vertex_c_x, i_in.vertex_c_y,
                i_in.center_x, i_in.center_y, longint'(i_in.radius));
            relation_fifo = {relation_fifo, pred};
        end
        if (i_rst_n && i_out.valid && i_out.ready) begin
            if (relation_fifo.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d: relation %0d with none expected",
                             result_index, i_out.relation);
            end else begin
                want = relation_fifo.pop_front();
                if (want !== i_out.relation) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d: relation expected %0d got %0d",
                                 result_index, want, i_out.relation);
                end
            end
            result_index++;
        end
    end

    assign o_fail_count = mismatch_count;
    assign o_pending    = relation_fifo.size();

endmodule

// ===== dv/triangle_circle_relation_core_tb.sv =====
// stimulus and verdict for the triangle / circle relation core
`timescale 1ns / 100ps

module triangle_circle_relation_core_tb;
    import tcr_pkg::*;

    localparam int N_RANDOM  = 1430;
    localparam int LONG_HOLD = 400;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   idle_on   = 1;
    bit   hold_req  = 0;

    tcr_in_if  in_ch ();
    tcr_out_if out_ch ();

    triangle_circle_relation_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    triangle_circle_relation_core_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // offer one request, after a random gap while idle_on is set, return once it is taken
    task automatic send(input int ax, ay, bx, by, cx, cy, px, py,
                        input logic [15:0] r);
        int gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.vertex_a_x <= 16'(ax);
        in_ch.vertex_a_y <= 16'(ay);
        in_ch.vertex_b_x <= 16'(bx);
        in_ch.vertex_b_y <= 16'(by);
        in_ch.vertex_c_x <= 16'(cx);
        in_ch.vertex_c_y <= 16'(cy);
        in_ch.center_x   <= 16'(px);
        in_ch.center_y   <= 16'(py);
        in_ch.radius     <= r;
        // ready is settled by mid-cycle, so look at it on the falling edge
        forever begin
            @(negedge i_clk);
            if (in_ch.ready) break;
        end
        @(posedge i_clk);
    endtask

    // one random request; mostly small shapes around the centre so all
    // four relations turn up, some full-range noise for the wide products
    task automatic send_random();
        int   kind;
        int   s;
        int   ax, ay, bx, by, cx, cy, px, py, k;
        kind = $urandom_range(0, 9);
        s  = 1 << $urandom_range(2, 13);
        px = $urandom_range(0, 65535) - 32768;
        py = $urandom_range(0, 65535) - 32768;
        px = px / 2;
        py = py / 2;
        ax = px + $urandom_range(0, 2 * s) - s;
        ay = py + $urandom_range(0, 2 * s) - s;
        bx = px + $urandom_range(0, 2 * s) - s;
        by = py + $urandom_range(0, 2 * s) - s;
        cx = px + $urandom_range(0, 2 * s) - s;
        cy = py + $urandom_range(0, 2 * s) - s;
        case (kind)
            0: begin
                // full-range noise on every field
                ax = $urandom; ay = $urandom; bx = $urandom; by = $urandom;
                cx = $urandom; cy = $urandom; px = $urandom; py = $urandom;
            end
            1: begin
                // collinear vertices
                k  = $urandom_range(0, 3) - 1;
                cx = ax + k * (bx - ax);
                cy = ay + k * (by - ay);
            end
            2: begin
                // point edge
                bx = ax;
                by = ay;
            end
            3: begin
                // centre on a vertex or an edge midpoint
                bx = ax + 2 * ((bx - ax) / 2);
                by = ay + 2 * ((by - ay) / 2);
                if ($urandom_range(0, 1)) begin
                    px = ax; py = ay;
                end else begin
                    px = (ax + bx) / 2; py = (ay + by) / 2;
                end
            end
            default: ;
        endcase
        send(ax, ay, bx, by, cx, cy, px, py,
             kind == 0 ? 16'($urandom) : 16'($urandom_range(0, 2 * s)));
    endtask

    // result side: random stall before each result while idle_on is set, one long hold on request
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = idle_on ? $urandom_range(0, 19) : 0;
            if (hold_req) begin
                stall    = LONG_HOLD;
                hold_req = 0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            forever begin
                @(negedge i_clk);
                if (out_ch.valid) break;
            end
            @(posedge i_clk);
        end
    end

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.vertex_a_x = '0;
        in_ch.vertex_a_y = '0;
        in_ch.vertex_b_x = '0;
        in_ch.vertex_b_y = '0;
        in_ch.vertex_c_x = '0;
        in_ch.vertex_c_y = '0;
        in_ch.center_x   = '0;
        in_ch.center_y   = '0;
        in_ch.radius     = '0;
        i_rst_n          = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every relation, degenerate shapes, boundary centres
        send(-32768, -32768, 32767, -32768, 0, 32767, 0, 0, 16'd100);
        send(-32768, -32768, 32767, -32768, 0, 32767, 0, 0, 16'hffff);
        send(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 16'd0);
        send(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 16'hffff);
        send(32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768, 16'hffff);
        send(-1, -1, -1, -1, -1, -1, -1, -1, 16'd0);
        send(0, 0, 100, 0, 0, 100, 10, 10, 16'd5);
        send(0, 0, 100, 0, 0, 100, 10, 10, 16'd50);
        send(0, 0, 10, 0, 0, 10, 2, 2, 16'd20);
        send(0, 0, 10, 0, 0, 10, 100, 100, 16'd5);
        send(0, 0, 10, 0, 0, 10, 20, 5, 16'd12);
        send(0, 0, 10, 0, 0, 10, 5, -3, 16'd3);
        send(0, 0, 10, 0, 20, 0, 5, 0, 16'd0);
        send(0, 0, 10, 0, 20, 0, 30, 0, 16'd0);
        send(0, 0, 10, 0, 20, 0, 5, 1, 16'd1);
        send(3, 4, 3, 4, 9, 9, 3, 4, 16'd0);
        send(3, 4, 3, 4, 9, 9, 0, 0, 16'd5);
        send(0, 0, 10, 0, 0, 10, 0, 0, 16'd0);
        send(0, 0, 10, 0, 0, 10, 5, 5, 16'd0);
        send(0, 0, 10, 0, 0, 10, 5, 5, 16'd1);
        send(7, 7, 7, 7, 7, 7, 7, 7, 16'd0);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 200 == 0) idle_on = (i / 200) % 3 != 1;
            if (i == 300) hold_req = 1;
            send_random();
        end
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        wait (pending == 0);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("triangle_circle_relation_core_tb passed");
        end else begin
            $display("triangle_circle_relation_core_tb failed");
        end
        $finish;
    end

    // worst case for ~1450 requests is far below this timeout
    initial begin
        #5ms;
        $display("triangle_circle_relation_core_tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tcr_pkg.sv
hdl/tcr_if.sv
hdl/tcr_wmul.sv
hdl/triangle_circle_relation_core.sv
dv/triangle_circle_relation_core_checker.sv
dv/triangle_circle_relation_core_tb.sv
